@@ src/gpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_pkg
// Shared widths, constants, register codes and types of the grid point dedup.
// ----------------------------------------------------------------------------
package gpd_pkg;

   localparam int COORD_W    = 20;
   localparam int FRAC_W     = 4;
   localparam int PIX_W      = COORD_W - FRAC_W;
   localparam int CELL_W     = 8;
   localparam int DIST_W     = 12;
   localparam int GRID_W     = 17;
   localparam int CNT_W      = 24;
   localparam int CELLS      = 65536;
   localparam int ADDR_W     = $clog2(CELLS);
   localparam int ENTRY_W    = 2 * COORD_W + 1;
   localparam int MUL_W      = COORD_W;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int LIM_W      = 2 * DIST_W;
   localparam int HOME_W     = PIX_W + GRID_W + 1;
   localparam int NIDX_W     = HOME_W + 2;
   localparam int DIV_CNT_W  = $clog2(PIX_W + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = GRID_W;

   localparam logic [CNT_W-1:0]  KEPT_MAX   = {CNT_W{1'b1}};
   localparam logic [DIST_W-1:0] DIST_RST   = DIST_W'(64);
   localparam logic [CELL_W-1:0] CELL_RST   = CELL_W'(4);
   localparam logic [GRID_W-1:0] COLS_RST   = GRID_W'(256);
   localparam logic [GRID_W-1:0] ROWS_RST   = GRID_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEDUP_DIST = 3'd0,
      CSR_CELL_SIZE  = 3'd1,
      CSR_GRID_COLS  = 3'd2,
      CSR_GRID_ROWS  = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic              start;
      logic [PIX_W-1:0]  dividend;
      logic [CELL_W-1:0] divisor;
   } div_req_type;

endpackage

@@ src/gpd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd channel interfaces
// Valid/ready channels for points, results and register writes.
// ----------------------------------------------------------------------------
interface gpd_req_if import gpd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] point_x;
   logic [COORD_W-1:0] point_y;
   modport source (output valid, point_x, point_y, input ready);
   modport sink (input valid, point_x, point_y, output ready);
endinterface

interface gpd_rsp_if import gpd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             keep;
   logic             out_of_grid;
   logic [CNT_W-1:0] kept_count;
   modport source (output valid, keep, out_of_grid, kept_count, input ready);
   modport sink (input valid, keep, out_of_grid, kept_count, output ready);
endinterface

interface gpd_csr_if import gpd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/gpd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/gpd_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_divider
// Restoring divider, one quotient bit per cycle, for cell coordinates.
// ----------------------------------------------------------------------------
module gpd_divider import gpd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      div_req,
   output logic             div_done,
   output logic [PIX_W-1:0] div_quo
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [PIX_W-1:0]     quo_ff, quo_in;
   logic [CELL_W-1:0]    rem_ff, rem_in;
   logic [CELL_W-1:0]    dvs_ff, dvs_in;
   logic [CELL_W:0]      trial;
   logic [CELL_W:0]      diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[PIX_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
         cnt_in = DIV_CNT_W'(PIX_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[CELL_W-1:0] : trial[CELL_W-1:0];
         quo_in  = {quo_ff[PIX_W-2:0], fits};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_done = done_ff;
   assign div_quo  = quo_ff;

endmodule

@@ src/grid_point_dedup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_point_dedup
// Grid-hashed spacing filter: keeps an on-grid point unless a stored point in the
// 3x3 neighborhood of its cell lies closer than the dedup distance. Off-grid points are not kept.
// ----------------------------------------------------------------------------
// operation: two divides on the shared divider give the cell; a point off the grid
//    ends there, else up to nine neighbors are read and compared, with the squares
//    formed on the one multiplier
// throughput: one point at a time, next transfer taken once the result is queued
// reset: clears the count and state, loads the register defaults, then sweeps the cell
//    store one entry a cycle, all 65536 entries, before the first point is taken
module grid_point_dedup import gpd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   gpd_csr_if.sink  csr_ch,
   gpd_req_if.sink  req_ch,
   gpd_rsp_if.source rsp_ch
);

   typedef enum logic [12:0] {
      ST_CLEAR = 13'b0000000000001,
      ST_IDLE  = 13'b0000000000010,
      ST_DIV   = 13'b0000000000100,
      ST_IDX   = 13'b0000000001000,
      ST_HOME  = 13'b0000000010000,
      ST_LIM   = 13'b0000000100000,
      ST_NADDR = 13'b0000001000000,
      ST_NDATA = 13'b0000010000000,
      ST_SQX   = 13'b0000100000000,
      ST_SQY   = 13'b0001000000000,
      ST_CMP   = 13'b0010000000000,
      ST_WRITE = 13'b0100000000000,
      ST_DONE  = 13'b1000000000000
   } state_type;

   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(CELLS - 1);

   state_type            state_ff, state_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic [CELL_W-1:0]    cell_ff, cell_in;
   logic [GRID_W-1:0]    cols_ff, cols_in;
   logic [GRID_W-1:0]    rows_ff, rows_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [COORD_W-1:0]   x_ff, x_in;
   logic [COORD_W-1:0]   y_ff, y_in;
   logic                 sel_ff, sel_in;
   logic [PIX_W-1:0]     cx_ff, cx_in;
   logic [PIX_W-1:0]     cy_ff, cy_in;
   logic [HOME_W-1:0]    home_ff, home_in;
   logic [LIM_W-1:0]     lim_ff, lim_in;
   logic [1:0]           ndx_ff, ndx_in;
   logic [1:0]           ndy_ff, ndy_in;
   logic [COORD_W-1:0]   ddx_ff, ddx_in;
   logic [COORD_W-1:0]   ddy_ff, ddy_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [PROD_W-1:0]    sq_ff, sq_in;
   logic                 res_keep_ff, res_keep_in;
   logic                 res_oog_ff, res_oog_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_keep_ff, rsp_keep_in;
   logic                 rsp_oog_ff, rsp_oog_in;
   logic [CNT_W-1:0]     rsp_cnt_ff, rsp_cnt_in;

   logic [MUL_W-1:0]     mul_a, mul_b;
   div_req_type          div_req;
   logic                 div_done;
   logic [PIX_W-1:0]     div_quo;
   logic [CELL_W-1:0]    cell_eff;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]   rd_data;
   logic [HOME_W-1:0]    home_calc;
   logic                 home_oog;
   logic [GRID_W-1:0]    ncx_p1, ncy_p1;
   logic [NIDX_W-1:0]    nidx;
   logic                 nbr_ok;
   logic                 nbr_last;
   logic [1:0]           nxt_ndx, nxt_ndy;
   logic [COORD_W-1:0]   ex, ey;
   logic [SUM_W-1:0]     dist_sum;

   gpd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   gpd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CELLS)
   ) u_cell_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // cell coordinate arithmetic
   assign cell_eff  = (cell_ff == '0) ? CELL_W'(1) : cell_ff;
   assign home_calc = HOME_W'(prod_ff) + HOME_W'(cx_ff);
   assign home_oog  = (GRID_W'(cx_ff) >= cols_ff) || (GRID_W'(cy_ff) >= rows_ff) ||
                      (home_calc >= HOME_W'(CELLS));

   assign ncx_p1 = GRID_W'(cx_ff) + GRID_W'(ndx_ff);
   assign ncy_p1 = GRID_W'(cy_ff) + GRID_W'(ndy_ff);
   assign nidx   = NIDX_W'(home_ff)
                 + ((ndy_ff == 2'd2) ? NIDX_W'(cols_ff) : '0)
                 + NIDX_W'(ndx_ff)
                 - ((ndy_ff == 2'd0) ? NIDX_W'(cols_ff) : '0)
                 - NIDX_W'(1);
   assign nbr_ok = (ncx_p1 != '0) && (ncx_p1 <= cols_ff) &&
                   (ncy_p1 != '0) && (ncy_p1 <= rows_ff) &&
                   (nidx < NIDX_W'(CELLS));
   assign rd_addr = nidx[ADDR_W-1:0];

   assign nbr_last = (ndx_ff == 2'd2) && (ndy_ff == 2'd2);
   assign nxt_ndy  = (ndy_ff == 2'd2) ? 2'd0 : ndy_ff + 2'd1;
   assign nxt_ndx  = (ndy_ff == 2'd2) ? ndx_ff + 2'd1 : ndx_ff;

   assign ex       = rd_data[2*COORD_W-1:COORD_W];
   assign ey       = rd_data[COORD_W-1:0];
   assign dist_sum = SUM_W'(sq_ff) + SUM_W'(prod_ff);

   // shared multiplier, registered output
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      dist_in = dist_ff;
      cell_in = cell_ff;
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DEDUP_DIST: dist_in = csr_ch.data[DIST_W-1:0];
            CSR_CELL_SIZE:  cell_in = csr_ch.data[CELL_W-1:0];
            CSR_GRID_COLS:  cols_in = csr_ch.data[GRID_W-1:0];
            CSR_GRID_ROWS:  rows_in = csr_ch.data[GRID_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      clr_in           = clr_ff;
      cnt_in           = cnt_ff;
      x_in             = x_ff;
      y_in             = y_ff;
      sel_in           = sel_ff;
      cx_in            = cx_ff;
      cy_in            = cy_ff;
      home_in          = home_ff;
      lim_in           = lim_ff;
      ndx_in           = ndx_ff;
      ndy_in           = ndy_ff;
      ddx_in           = ddx_ff;
      ddy_in           = ddy_ff;
      sq_in            = sq_ff;
      res_keep_in      = res_keep_ff;
      res_oog_in       = res_oog_ff;
      rsp_valid_in     = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      rsp_keep_in      = rsp_keep_ff;
      rsp_oog_in       = rsp_oog_ff;
      rsp_cnt_in       = rsp_cnt_ff;
      mul_a            = ddx_ff;
      mul_b            = ddx_ff;
      div_req.start    = 1'b0;
      div_req.dividend = y_ff[COORD_W-1:FRAC_W];
      div_req.divisor  = cell_eff;
      wr_en            = 1'b0;
      wr_addr          = home_ff[ADDR_W-1:0];
      wr_data          = {1'b1, x_ff, y_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               x_in             = req_ch.point_x;
               y_in             = req_ch.point_y;
               sel_in           = 1'b0;
               div_req.start    = 1'b1;
               div_req.dividend = req_ch.point_x[COORD_W-1:FRAC_W];
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (!sel_ff) begin
                  cx_in         = div_quo;
                  sel_in        = 1'b1;
                  div_req.start = 1'b1;
               end else begin
                  cy_in    = div_quo;
                  state_in = ST_IDX;
               end
            end
         end
         ST_IDX: begin
            mul_a    = MUL_W'(cy_ff);
            mul_b    = MUL_W'(cols_ff);
            state_in = ST_HOME;
         end
         ST_HOME: begin
            home_in     = home_calc;
            mul_a       = MUL_W'(dist_ff);
            mul_b       = MUL_W'(dist_ff);
            res_keep_in = 1'b0;
            res_oog_in  = home_oog;
            state_in    = home_oog ? ST_DONE : ST_LIM;
         end
         ST_LIM: begin
            lim_in   = prod_ff[LIM_W-1:0];
            ndx_in   = 2'd0;
            ndy_in   = 2'd0;
            state_in = ST_NADDR;
         end
         ST_NADDR: begin
            if (nbr_ok) begin
               state_in = ST_NDATA;
            end else if (nbr_last) begin
               state_in = ST_WRITE;
            end else begin
               ndx_in = nxt_ndx;
               ndy_in = nxt_ndy;
            end
         end
         ST_NDATA: begin
            ddx_in = (ex > x_ff) ? ex - x_ff : x_ff - ex;
            ddy_in = (ey > y_ff) ? ey - y_ff : y_ff - ey;
            if (rd_data[ENTRY_W-1]) begin
               state_in = ST_SQX;
            end else if (nbr_last) begin
               state_in = ST_WRITE;
            end else begin
               ndx_in   = nxt_ndx;
               ndy_in   = nxt_ndy;
               state_in = ST_NADDR;
            end
         end
         ST_SQX: begin
            state_in = ST_SQY;
         end
         ST_SQY: begin
            mul_a    = ddy_ff;
            mul_b    = ddy_ff;
            sq_in    = prod_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (dist_sum < SUM_W'(lim_ff)) begin
               res_keep_in = 1'b0;
               state_in    = ST_DONE;
            end else if (nbr_last) begin
               state_in = ST_WRITE;
            end else begin
               ndx_in   = nxt_ndx;
               ndy_in   = nxt_ndy;
               state_in = ST_NADDR;
            end
         end
         ST_WRITE: begin
            wr_en       = 1'b1;
            res_keep_in = 1'b1;
            if (cnt_ff != KEPT_MAX) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_keep_in  = res_keep_ff;
               rsp_oog_in   = res_oog_ff;
               rsp_cnt_in   = cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dist_ff      <= DIST_RST;
         cell_ff      <= CELL_RST;
         cols_ff      <= COLS_RST;
         rows_ff      <= ROWS_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         dist_ff      <= dist_in;
         cell_ff      <= cell_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      sel_ff      <= sel_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      home_ff     <= home_in;
      lim_ff      <= lim_in;
      ndx_ff      <= ndx_in;
      ndy_ff      <= ndy_in;
      ddx_ff      <= ddx_in;
      ddy_ff      <= ddy_in;
      prod_ff     <= prod_in;
      sq_ff       <= sq_in;
      res_keep_ff <= res_keep_in;
      res_oog_ff  <= res_oog_in;
      rsp_keep_ff <= rsp_keep_in;
      rsp_oog_ff  <= rsp_oog_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign csr_ch.ready       = 1'b1;
   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.keep        = rsp_keep_ff;
   assign rsp_ch.out_of_grid = rsp_oog_ff;
   assign rsp_ch.kept_count  = rsp_cnt_ff;

endmodule

@@ src/gpd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_checker
// Port-level checks of the grid point dedup, bound to the top level.
// ----------------------------------------------------------------------------
module gpd_checker import gpd_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_keep,
   input logic             rsp_out_of_grid,
   input logic [CNT_W-1:0] rsp_kept_count
);

   logic [1:0]       pend_ff, pend_in;
   logic [CNT_W-1:0] last_cnt_ff, last_cnt_in;
   logic             req_xfer;
   logic             rsp_xfer;
   logic [CNT_W-1:0] cnt_after_keep;

   assign req_xfer       = req_valid && req_ready;
   assign rsp_xfer       = rsp_valid && rsp_ready;
   assign cnt_after_keep = (last_cnt_ff == KEPT_MAX) ? KEPT_MAX : last_cnt_ff + CNT_W'(1);

   always_comb begin
      pend_in     = pend_ff + (req_xfer ? 2'd1 : 2'd0) - (rsp_xfer ? 2'd1 : 2'd0);
      last_cnt_in = rsp_xfer ? rsp_kept_count : last_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         last_cnt_ff <= '0;
      end else begin
         pend_ff     <= pend_in;
         last_cnt_ff <= last_cnt_in;
      end
   end

   // stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // an off-grid point is never kept
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_grid |-> !rsp_keep)
      else $error("off-grid point reported as kept");

   // count moves by one per kept point, saturating
   assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> (rsp_keep ? (rsp_kept_count == cnt_after_keep)
                             : (rsp_kept_count == last_cnt_ff)))
      else $error("kept count inconsistent with keep");

   // a result always belongs to a transferred point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a pending point");

   // at most one point in work besides a queued result
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> pend_ff <= 2'd1)
      else $error("too many points in flight");

endmodule

bind grid_point_dedup gpd_checker u_gpd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_keep        (rsp_ch.keep),
   .rsp_out_of_grid (rsp_ch.out_of_grid),
   .rsp_kept_count  (rsp_ch.kept_count)
);
